// ----- rtl/core/bfpa_pkg.sv -----
// Shared constants, codes and interface types for the best-fit partition allocator.
`default_nettype none
package bfpa_pkg;

  localparam int NUM_PARTS = 16;
  localparam int ADDR_BITS = 16;
  localparam int ID_BITS   = 6;

  localparam int IDX_W  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CMP_W  = (ADDR_BITS > 16) ? ADDR_BITS : 16;

  localparam int ACT_W  = 2;
  localparam int SLOT_W = 4;
  localparam int FLD_W  = 16;
  localparam int OWN_W  = 6;
  localparam int PIDX_W = 4;

  typedef enum logic [1:0] {
    ACT_DEFINE  = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOTHING = 2'd3
  } status_t;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ID_BITS-1:0]   id_t;

  typedef struct packed {
    logic  def_we;
    idx_t  def_idx;
    addr_t def_base;
    addr_t def_len;
    logic  set_we;
    logic  clr_we;
    idx_t  sel_idx;
    id_t   owner;
  } tbl_wr_t;

  typedef struct packed {
    addr_t base;
    addr_t len;
    logic  busy;
    id_t   owner;
  } tbl_rd_t;

  typedef struct packed {
    logic fits;
    logic better;
  } cmp_res_t;

  typedef struct packed {
    status_t             status;
    logic [PIDX_W-1:0]   idx;
    logic [FLD_W-1:0]    base;
    logic [FLD_W-1:0]    len;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/bfpa_table.sv -----
// Partition table: base, length, owner and busy flag per entry, one scan read port.
`default_nettype none
module bfpa_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bfpa_pkg::tbl_wr_t wr,
  input  wire bfpa_pkg::idx_t    rd_idx,
  output bfpa_pkg::tbl_rd_t      rd
);

  localparam int NP = bfpa_pkg::NUM_PARTS;

  bfpa_pkg::addr_t base_r  [NP];
  bfpa_pkg::addr_t len_r   [NP];
  bfpa_pkg::id_t   owner_r [NP];
  logic [NP-1:0]   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      for (int i = 0; i < NP; i++) begin
        base_r[i]  <= '0;
        len_r[i]   <= '0;
        owner_r[i] <= '0;
      end
    end else begin
      if (wr.def_we) begin
        base_r[wr.def_idx] <= wr.def_base;
        len_r[wr.def_idx]  <= wr.def_len;
      end
      if (wr.set_we) begin
        busy_r[wr.sel_idx]  <= 1'b1;
        owner_r[wr.sel_idx] <= wr.owner;
      end
      if (wr.clr_we) begin
        busy_r[wr.sel_idx] <= 1'b0;
      end
    end
  end

  assign rd.base  = base_r[rd_idx];
  assign rd.len   = len_r[rd_idx];
  assign rd.busy  = busy_r[rd_idx];
  assign rd.owner = owner_r[rd_idx];

endmodule
`default_nettype wire

// ----- rtl/core/bfpa_cmp.sv -----
// Shared size compare unit: fit against the request, and better than the best so far.
`default_nettype none
module bfpa_cmp (
  input  wire bfpa_pkg::addr_t              len,
  input  wire logic [bfpa_pkg::FLD_W-1:0]   req,
  input  wire bfpa_pkg::addr_t              best_len,
  input  wire logic                         found,
  output bfpa_pkg::cmp_res_t                res
);

  localparam int CW = bfpa_pkg::CMP_W;

  assign res.fits   = CW'(len) >= CW'(req);
  assign res.better = !found || (len < best_len);

endmodule
`default_nettype wire

// ----- rtl/core/bfpa_ctrl.sv -----
// Sequencer: takes one item, scans the table one entry a cycle, forms the result.
`default_nettype none
module bfpa_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire bfpa_pkg::action_t           action,
  input  wire logic [bfpa_pkg::SLOT_W-1:0] slot,
  input  wire logic [bfpa_pkg::FLD_W-1:0]  base_in,
  input  wire logic [bfpa_pkg::FLD_W-1:0]  length_in,
  input  wire logic [bfpa_pkg::FLD_W-1:0]  request_size,
  input  wire logic [bfpa_pkg::OWN_W-1:0]  owner_id,
  output bfpa_pkg::idx_t                   rd_idx,
  input  wire bfpa_pkg::tbl_rd_t           rd,
  output bfpa_pkg::addr_t                  cmp_best,
  output logic                             cmp_found,
  output logic [bfpa_pkg::FLD_W-1:0]       cmp_req,
  input  wire bfpa_pkg::cmp_res_t          cmp,
  output bfpa_pkg::tbl_wr_t                wr,
  output logic                             res_valid,
  output bfpa_pkg::result_t                res,
  input  wire logic                        res_take
);

  localparam int IW = bfpa_pkg::IDX_W;
  localparam int AW = bfpa_pkg::ADDR_BITS;
  localparam int DW = bfpa_pkg::ID_BITS;
  localparam int FW = bfpa_pkg::FLD_W;
  localparam int PW = bfpa_pkg::PIDX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  bfpa_pkg::action_t     act_r, act_nxt;
  logic [FW-1:0]         req_r, req_nxt;
  bfpa_pkg::id_t         own_r, own_nxt;
  bfpa_pkg::idx_t        idx_r, idx_nxt;
  logic                  any_r, any_nxt;
  logic                  found_r, found_nxt;
  bfpa_pkg::idx_t        best_idx_r, best_idx_nxt;
  bfpa_pkg::addr_t       best_len_r, best_len_nxt;
  bfpa_pkg::addr_t       best_base_r, best_base_nxt;
  bfpa_pkg::result_t     res_r, res_nxt;
  logic                  last;
  logic                  hit;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign rd_idx    = idx_r;
  assign cmp_best  = best_len_r;
  assign cmp_found = found_r;
  assign cmp_req   = req_r;
  assign last      = (idx_r == IW'(bfpa_pkg::NUM_PARTS - 1));
  assign hit       = rd.busy && (rd.owner == own_r);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    req_nxt       = req_r;
    own_nxt       = own_r;
    idx_nxt       = idx_r;
    any_nxt       = any_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_len_nxt  = best_len_r;
    best_base_nxt = best_base_r;
    res_nxt       = res_r;
    wr            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = action;
          req_nxt   = request_size;
          own_nxt   = DW'(owner_id);
          idx_nxt   = '0;
          any_nxt   = 1'b0;
          found_nxt = 1'b0;
          res_nxt   = '{bfpa_pkg::ST_NOTHING, '0, '0, '0};
          unique case (action) inside
            bfpa_pkg::ACT_DEFINE: begin
              res_nxt = '{bfpa_pkg::ST_OK, PW'(slot), '0, '0};
              if (32'(slot) < bfpa_pkg::NUM_PARTS) begin
                wr.def_we    = 1'b1;
                wr.def_idx   = IW'(slot);
                wr.def_base  = AW'(base_in);
                wr.def_len   = AW'(length_in);
                res_nxt.base = FW'(AW'(base_in));
                res_nxt.len  = FW'(AW'(length_in));
              end
              state_nxt = S_DONE;
            end
            bfpa_pkg::ACT_ALLOC, bfpa_pkg::ACT_RELEASE: state_nxt = S_SCAN;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (act_r == bfpa_pkg::ACT_RELEASE) begin
          if (hit) begin
            wr.clr_we  = 1'b1;
            wr.sel_idx = idx_r;
            res_nxt    = '{bfpa_pkg::ST_OK, PW'(idx_r), FW'(rd.base), FW'(rd.len)};
            state_nxt  = S_DONE;
          end else if (last) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          if (cmp.fits) begin
            any_nxt = 1'b1;
            if (!rd.busy && cmp.better) begin
              found_nxt     = 1'b1;
              best_idx_nxt  = idx_r;
              best_len_nxt  = rd.len;
              best_base_nxt = rd.base;
            end
          end
          if (last) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!any_r) begin
          res_nxt = '{bfpa_pkg::ST_TOO_BIG, '0, '0, '0};
        end else if (!found_r) begin
          res_nxt = '{bfpa_pkg::ST_FULL, '0, '0, '0};
        end else begin
          wr.set_we  = 1'b1;
          wr.sel_idx = best_idx_r;
          wr.owner   = own_r;
          res_nxt    = '{bfpa_pkg::ST_OK, PW'(best_idx_r), FW'(best_base_r), FW'(best_len_r)};
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      any_r   <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    req_r       <= req_nxt;
    own_r       <= own_nxt;
    best_idx_r  <= best_idx_nxt;
    best_len_r  <= best_len_nxt;
    best_base_r <= best_base_nxt;
    res_r       <= res_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/best_fit_partition_allocator.sv -----
// Best-fit fixed-partition allocator top level with output register.
// Define and unused actions go straight to the result; allocate scans one table entry
// per cycle over 16 entries, then a finish step; release scans until the owner's entry is hit.
// Throughput: one item at a time, set by the single-entry table scan of the sequencer;
// a new item is taken the cycle after the previous result moves to the output register.
// Reset: synchronous active-low rst_n clears the table, sequencer state, scan index and flags, and output valid.
`default_nettype none
module best_fit_partition_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // slot[3:0], base_in[19:4], length_in[35:20], request_size[51:36], owner_id[57:52], zero
  input  wire logic [63:0] in_tdata,
  // action[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // part_index[3:0], base_out[19:4], length_out[35:20], zero[39:36]
  output logic [39:0]      out_tdata,
  // status[1:0]
  output logic [1:0]       out_tuser
);

  bfpa_pkg::tbl_wr_t               wr;
  bfpa_pkg::tbl_rd_t               rd;
  bfpa_pkg::idx_t                  rd_idx;
  bfpa_pkg::addr_t                 cmp_best;
  logic                            cmp_found;
  logic [bfpa_pkg::FLD_W-1:0]      cmp_req;
  bfpa_pkg::cmp_res_t              cmp;
  logic                            res_valid;
  bfpa_pkg::result_t               res;
  logic                            res_take;
  logic                            out_valid_r;
  bfpa_pkg::result_t               out_res_r;

  bfpa_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  bfpa_cmp u_cmp (
    .len      (rd.len),
    .req      (cmp_req),
    .best_len (cmp_best),
    .found    (cmp_found),
    .res      (cmp)
  );

  bfpa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .action       (bfpa_pkg::action_t'(in_tuser)),
    .slot         (in_tdata[3:0]),
    .base_in      (in_tdata[19:4]),
    .length_in    (in_tdata[35:20]),
    .request_size (in_tdata[51:36]),
    .owner_id     (in_tdata[57:52]),
    .rd_idx       (rd_idx),
    .rd           (rd),
    .cmp_best     (cmp_best),
    .cmp_found    (cmp_found),
    .cmp_req      (cmp_req),
    .cmp          (cmp),
    .wr           (wr),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0, out_res_r.len, out_res_r.base, out_res_r.idx};

  // no new transfer is taken while an item is in progress
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while item in progress");

  // failed results carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == bfpa_pkg::ST_TOO_BIG || out_tuser == bfpa_pkg::ST_FULL
      || out_tuser == bfpa_pkg::ST_NOTHING)) |-> (out_tdata == '0))
    else $error("failed result with nonzero payload");

  // a result handed to the output stage frees the sequencer next cycle
  a_take_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (in_tready && out_tvalid))
    else $error("sequencer not idle after result handoff");

endmodule
`default_nettype wire

// ----- tb/tb_alloc_sb_pkg.sv -----
// Partition table predictor and result scoreboard for the best-fit partition allocator bench.
package tb_alloc_sb_pkg;
  import bfpa_pkg::*;

  class alloc_scoreboard;
    addr_t   part_base  [NUM_PARTS];
    addr_t   part_len   [NUM_PARTS];
    logic    part_busy  [NUM_PARTS];
    id_t     part_owner [NUM_PARTS];
    result_t expected_grants[$];
    int      errors;

    function new();
      errors = 0;
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_base[i]  = '0;
        part_len[i]   = '0;
        part_busy[i]  = 1'b0;
        part_owner[i] = '0;
      end
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // Applies one accepted request to the table copy and queues its reply.
    function void record_request(action_t act, logic [SLOT_W-1:0] slot, addr_t base_in,
                                 addr_t len_in, logic [FLD_W-1:0] req, id_t owner);
      result_t r;
      logic    any_fit;
      logic    found;
      int      best;
      r        = '0;
      r.status = ST_OK;
      any_fit  = 1'b0;
      found    = 1'b0;
      best     = 0;
      case (act)
        ACT_DEFINE: begin
          r.idx = slot;
          if (slot < NUM_PARTS) begin
            part_base[slot] = base_in;
            part_len[slot]  = len_in;
            r.base          = base_in;
            r.len           = len_in;
          end
        end
        ACT_ALLOC: begin
          for (int i = 0; i < NUM_PARTS; i++) begin
            if (part_len[i] >= req) begin
              any_fit = 1'b1;
              if (!part_busy[i] && (!found || part_len[i] < part_len[best])) begin
                best  = i;
                found = 1'b1;
              end
            end
          end
          if (!any_fit) begin
            r.status = ST_TOO_BIG;
          end else if (!found) begin
            r.status = ST_FULL;
          end else begin
            part_busy[best]  = 1'b1;
            part_owner[best] = owner;
            r.idx            = PIDX_W'(best);
            r.base           = part_base[best];
            r.len            = part_len[best];
          end
        end
        ACT_RELEASE: begin
          r.status = ST_NOTHING;
          for (int i = 0; i < NUM_PARTS; i++) begin
            if (!found && part_busy[i] && part_owner[i] == owner) begin
              found        = 1'b1;
              part_busy[i] = 1'b0;
              r.status     = ST_OK;
              r.idx        = PIDX_W'(i);
              r.base       = part_base[i];
              r.len        = part_len[i];
            end
          end
        end
        default: begin
          r.status = ST_NOTHING;
        end
      endcase
      expected_grants.push_back(r);
    endfunction

    function void check_grant(result_t got);
      result_t want;
      if (expected_grants.size() == 0) begin
        $error("unexpected result: status %0d index %0d base %0h length %0h",
               got.status, got.idx, got.base, got.len);
        errors++;
        return;
      end
      want = expected_grants.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $error("part_index: expected %0d, actual %0d", want.idx, got.idx);
        errors++;
      end
      if (got.base !== want.base) begin
        $error("base_out: expected %0h, actual %0h", want.base, got.base);
        errors++;
      end
      if (got.len !== want.len) begin
        $error("length_out: expected %0h, actual %0h", want.len, got.len);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level testbench for the best-fit partition allocator: stimulus, flow control, checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfpa_pkg::*;
  import tb_alloc_sb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 25;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_len    = 0;
  int cycle_count = 0;

  alloc_scoreboard sb = new();

  best_fit_partition_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        hold_len = hold_len - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.idx    = out_tdata[3:0];
      got.base   = out_tdata[19:4];
      got.len    = out_tdata[35:20];
      sb.check_grant(got);
    end
  end

  task automatic send_item(action_t act, logic [3:0] slot, addr_t base_in, addr_t len_in,
                           logic [15:0] req, id_t owner);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'b0, owner, req, len_in, base_in, slot};
    do @(posedge clk); while (!in_tready);
    sb.record_request(act, slot, base_in, len_in, req, owner);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(9)) inside
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(300));
    endcase
  endfunction

  // mostly a small pool of owners so releases find something
  function automatic id_t pick_owner();
    return ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(5));
  endfunction

  task automatic send_random(int count);
    int      r;
    action_t act;
    repeat (count) begin
      r   = $urandom_range(99);
      act = (r < 25) ? ACT_DEFINE : (r < 65) ? ACT_ALLOC : (r < 95) ? ACT_RELEASE : ACT_NONE;
      send_item(act, 4'($urandom), 16'($urandom), pick_size(), pick_size(), pick_owner());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 28;
    recv_idle = 57;
    // empty table: zero request fits a zero-length partition
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd5);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'h0001, 6'd5);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd7);
    send_item(ACT_RELEASE, 4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd5);
    send_item(ACT_RELEASE, 4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd5);
    send_item(ACT_RELEASE, 4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd7);
    send_item(ACT_NONE,    4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
    send_item(ACT_DEFINE,  4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
    send_item(ACT_DEFINE,  4'h3, 16'h1234, 16'd100,  16'h0000, 6'd0);
    send_item(ACT_DEFINE,  4'h7, 16'h0ABC, 16'd100,  16'h0000, 6'd0);
    send_item(ACT_DEFINE,  4'h9, 16'h4000, 16'd50,   16'h0000, 6'd0);
    // equal lengths: lowest index first
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'd100,  6'd63);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'd100,  6'd63);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'd51,   6'd0);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'd51,   6'd0);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'hFFFF, 6'd0);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'd50,   6'd2);
    // redefine a busy slot: busy flag and owner stay
    send_item(ACT_DEFINE,  4'h7, 16'h8000, 16'd10,   16'h0000, 6'd0);
    send_item(ACT_RELEASE, 4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd63);
    send_item(ACT_RELEASE, 4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd63);
    send_item(ACT_ALLOC,   4'h0, 16'h0000, 16'h0000, 16'd1,    6'd4);
    send_item(ACT_DEFINE,  4'h0, 16'h0000, 16'h0000, 16'h0000, 6'd0);
    send_random(150);
    wait_idle();

    send_idle = 57;
    recv_idle = 28;
    send_random(160);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    hold_len  = 400;
    send_random(170);
    wait_idle();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
